### hw/rtl/circular_next_date_lookup_core_assert.svh
// Assertion macros used by the checker file.
`ifndef CIRCULAR_NEXT_DATE_LOOKUP_CORE_ASSERT_SVH
`define CIRCULAR_NEXT_DATE_LOOKUP_CORE_ASSERT_SVH

// Checked only while out of reset.
`define CNDL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CNDL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/cndl_pkg.sv
package cndl_pkg;

    localparam int DAY_W = 9;
    localparam int MEM_W = 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [3:0] month;
        logic [4:0] day;
        logic [7:0] member_id;
    } t_in;

    typedef struct packed {
        logic [7:0] found_id;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [MEM_W-1:0] member;
    } t_entry;

    typedef struct packed {
        logic day_lt;   // a.day < b.day
        logic precedes; // a sorts strictly ahead of b
    } t_cmp_res;

    // Non-leap month offsets; out-of-range months map to zero.
    function automatic logic [DAY_W-1:0] month_offset(input logic [3:0] month);
        logic [DAY_W-1:0] off;
        case (month)
            4'd2:    off = 9'd31;
            4'd3:    off = 9'd59;
            4'd4:    off = 9'd90;
            4'd5:    off = 9'd120;
            4'd6:    off = 9'd151;
            4'd7:    off = 9'd181;
            4'd8:    off = 9'd212;
            4'd9:    off = 9'd243;
            4'd10:   off = 9'd273;
            4'd11:   off = 9'd304;
            4'd12:   off = 9'd334;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    function automatic logic [DAY_W-1:0] day_of_year(input logic [3:0] month,
                                                     input logic [4:0] day);
        return month_offset(month) + {4'd0, day};
    endfunction

endpackage

### hw/rtl/circular_next_date_lookup_core.sv
// Circular next-date lookup core.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction is an
// insert (cmd 0: month, day, member id) or a query (cmd 1: month, day).
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// transaction per input, in order: found id and status (ok, full, empty).
//
// One transaction at a time. o_in_ready is high only while idle.
// Insert: stored entries are shifted one entry per cycle from the tail toward
// the head, and the new entry lands in its sorted place. Full table: ST_FULL.
// Query: linear scan from entry 0, one entry per cycle; empty table: ST_EMPTY.
// The scan rate is set by the single read port of the table RAM and the one
// shared comparator, used once per visited entry.
//
// Reset clears the entry count and returns to idle; table contents are not
// cleared (only entries below the count are ever read).
// A stalled receiver holds the result in the output register; no new input
// is taken until the result transaction completes.
module circular_next_date_lookup_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cndl_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cndl_pkg::t_out o_out_data
);
    import cndl_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_INS   = 6'b000100,
        S_PLACE = 6'b001000,
        S_QRY   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx,   n_idx;
    logic             r_cmd,   n_cmd;
    t_entry           r_new,   n_new;     // converted date and id of the item
    logic [MEM_W-1:0] r_first, n_first;   // id of entry 0, for wraparound
    t_out             r_out,   n_out;

    // table RAM port
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    t_entry           wdata, rdata;

    // shared comparator
    t_entry           cmp_a, cmp_b;
    t_cmp_res         cmp;

    cndl_table_ram #(.DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Insert asks "new before stored?", query asks "stored day below new?".
    assign cmp_a = (r_state == S_QRY) ? rdata : r_new;
    assign cmp_b = (r_state == S_QRY) ? r_new : rdata;

    cndl_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_cmd   = r_cmd;
        n_new   = r_new;
        n_first = r_first;
        n_out   = r_out;
        we      = 1'b0;
        waddr   = '0;
        wdata   = r_new;
        re      = 1'b0;
        raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_in_data.cmd;
                    n_new.day    = day_of_year(i_in_data.month, i_in_data.day);
                    n_new.member = i_in_data.member_id;
                    n_state      = S_START;
                end
            end
            S_START: begin
                n_out.found_id = '0;
                n_out.status   = ST_OK;
                if (r_cmd == CMD_INSERT) begin
                    if (r_count == CW'(MAX_ENTRIES)) begin
                        n_out.status = ST_FULL;
                        n_state      = S_OUT;
                    end else if (r_count == '0) begin
                        we      = 1'b1;
                        waddr   = '0;
                        n_count = r_count + 1'b1;
                        n_state = S_OUT;
                    end else begin
                        // fetch the last entry; walk toward the head
                        re      = 1'b1;
                        raddr   = AW'(r_count - 1'b1);
                        n_idx   = r_count;
                        n_state = S_INS;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                        n_state      = S_OUT;
                    end else begin
                        re      = 1'b1;
                        raddr   = '0;
                        n_idx   = '0;
                        n_state = S_QRY;
                    end
                end
            end
            S_INS: begin
                // rdata holds entry r_idx-1
                if (cmp.precedes) begin
                    we    = 1'b1;
                    waddr = AW'(r_idx);
                    wdata = rdata;
                    n_idx = r_idx - 1'b1;
                    if (r_idx == CW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        re    = 1'b1;
                        raddr = AW'(r_idx - CW'(2));
                    end
                end else begin
                    we      = 1'b1;
                    waddr   = AW'(r_idx);
                    n_count = r_count + 1'b1;
                    n_state = S_OUT;
                end
            end
            S_PLACE: begin
                // new entry goes to the head
                we      = 1'b1;
                waddr   = AW'(r_idx);
                n_count = r_count + 1'b1;
                n_state = S_OUT;
            end
            S_QRY: begin
                // rdata holds entry r_idx
                if (r_idx == '0) begin
                    n_first = rdata.member;
                end
                if (!cmp.day_lt) begin
                    n_out.found_id = rdata.member;
                    n_state        = S_OUT;
                end else if ((r_idx + 1'b1) == r_count) begin
                    // nothing on or after the date: wrap to the earliest
                    n_out.found_id = (r_idx == '0) ? rdata.member : r_first;
                    n_state        = S_OUT;
                end else begin
                    re    = 1'b1;
                    raddr = AW'(r_idx + 1'b1);
                    n_idx = r_idx + 1'b1;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx   <= n_idx;
        r_cmd   <= n_cmd;
        r_new   <= n_new;
        r_first <= n_first;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule

### hw/rtl/cndl_table_ram.sv
module cndl_table_ram #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  cndl_pkg::t_entry             i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output cndl_pkg::t_entry             o_rdata
);
    import cndl_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/cndl_cmp.sv
module cndl_cmp (
    input  cndl_pkg::t_entry   i_a,
    input  cndl_pkg::t_entry   i_b,
    output cndl_pkg::t_cmp_res o_res
);
    import cndl_pkg::*;

    logic day_lt;
    logic day_eq;

    assign day_lt         = i_a.day < i_b.day;
    assign day_eq         = i_a.day == i_b.day;
    assign o_res.day_lt   = day_lt;
    assign o_res.precedes = day_lt || (day_eq && (i_a.member < i_b.member));

endmodule

### hw/rtl/cndl_checker.sv
`include "circular_next_date_lookup_core_assert.svh"

module cndl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input cndl_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input cndl_pkg::t_out o_out_data
);
    import cndl_pkg::*;

    // stalled result holds
    `CNDL_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")

    // one transaction in flight: never ready while a result waits
    `CNDL_ASSERT(a_one_in_flight, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "input ready while result pending")

    // accepted input closes the input side
    `CNDL_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "ready held after accept")

    // status codes and zero id on non-ok results
    `CNDL_ASSERT(a_status_legal, i_clk, i_rst_n, o_out_valid |-> (o_out_data.status == ST_OK) || ((o_out_data.status == ST_FULL || o_out_data.status == ST_EMPTY) && o_out_data.found_id == 8'd0), "bad status or id")

    // reset flushes any pending result
    `CNDL_ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind circular_next_date_lookup_core cndl_checker u_cndl_checker (.*);
